>>> hw/rtl/whdp_pkg.sv
// ----------------------------------------------------------------------------
// WOFF header directory parser package
// Shared constants, status codes and result item types.
// ----------------------------------------------------------------------------
package whdp_pkg;

   localparam int COUNT_BITS   = 32;
   localparam int HEADER_BYTES = 44;
   localparam int RECORD_BYTES = 20;
   localparam int RSP_DEPTH    = 4;
   localparam int PTR_BITS     = $clog2(RSP_DEPTH);
   localparam int LEVEL_BITS   = $clog2(RSP_DEPTH + 1);
   localparam int POS_BITS     = $clog2(RECORD_BYTES);
   localparam int NEED_BITS    = 22;

   localparam logic [31:0] WOFF_MAGIC = 32'h774F_4646;

   localparam logic KIND_RECORD = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [PTR_BITS-1:0]   ptr_type;
   typedef logic [LEVEL_BITS-1:0] level_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_SHORT     = 3'd1,
      ST_BAD_SIG   = 3'd2,
      ST_LEN_MISM  = 3'd3,
      ST_TRUNC_DIR = 3'd4,
      ST_OUTSIDE   = 3'd5
   } status_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] table_index;
      logic [31:0] tag;
      logic [31:0] table_offset;
      logic [31:0] comp_length;
      logic [31:0] orig_length;
      logic [31:0] table_checksum;
      logic        is_compressed;
      logic        out_of_bounds;
      status_type  status;
      logic [31:0] flavor;
      logic        last_out;
   } rsp_type;

   typedef struct packed {
      logic    rec_valid;
      logic    stat_valid;
      rsp_type rec;
      rsp_type stat;
   } push_type;

endpackage

>>> hw/rtl/woff_header_directory_parser.sv
// ----------------------------------------------------------------------------
// WOFF header directory parser
// Parses a WOFF 1.0 byte stream into table directory records and a status.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                          | tuser | tlast
//  req     | in  | data_byte                      | -     | last
//  rsp     | out | record / status fields (216b)  | kind  | last_out
//
//  One byte per cycle sustained while the queue has room; a taken byte waits
//  in an input register, and its results reach rsp through the result queue.
//  The four-entry result queue absorbs the record plus status pair that a
//  final byte may give; bytes are held off while two slots are not free.
//  Reset clears the parser state and the queue; after each final byte the
//  parser returns to its reset state by itself.
module woff_header_directory_parser (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [215:0] rsp_tdata,   // table_index, tag, table_offset, comp_length,
                                     // orig_length, table_checksum, is_compressed,
                                     // out_of_bounds, status, flavor, zero pad
   output logic         rsp_tuser,   // kind
   output logic         rsp_tlast
);
   import whdp_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       take;
   push_type   push;
   rsp_type    head;
   level_type  level;

   assign take       = in_valid_ff && (level <= level_type'(RSP_DEPTH - 2));
   assign req_tready = !in_valid_ff || take;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   whdp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .item_valid (take),
      .data_byte  (in_byte_ff),
      .last       (in_last_ff),
      .push       (push)
   );

   whdp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .head       (head),
      .head_valid (rsp_tvalid),
      .pop        (rsp_tready),
      .level      (level)
   );

   assign rsp_tdata = {3'b000, head.flavor, head.status, head.out_of_bounds,
                       head.is_compressed, head.table_checksum, head.orig_length,
                       head.comp_length, head.table_offset, head.tag,
                       head.table_index};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last_out;

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level <= level_type'(RSP_DEPTH))
      else $error("result queue overfilled");

   a_hold_off: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && level > level_type'(RSP_DEPTH - 2)) |-> !req_tready)
      else $error("byte taken without room for two items");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == rsp_tlast))
      else $error("status item and last marker disagree");

   a_two_push: assert property (@(posedge clock) disable iff (reset)
      (push.rec_valid && push.stat_valid) |=> (level >= level_type'(2)))
      else $error("record and status pair not both queued");

endmodule

>>> hw/rtl/whdp_parser.sv
// ----------------------------------------------------------------------------
// WOFF header directory parser: byte parser
// Header capture, directory record assembly and end-of-file status.
// ----------------------------------------------------------------------------
module whdp_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  logic [7:0]        data_byte,
   input  logic              last,
   output whdp_pkg::push_type push
);
   import whdp_pkg::*;

   count_type   byte_count_ff, byte_count_in;
   logic [31:0] word_shift_ff, word_shift_in;
   logic [31:0] signature_ff, signature_in;
   logic [31:0] flavor_ff, flavor_in;
   logic [31:0] declared_ff, declared_in;
   logic [15:0] table_count_ff, table_count_in;
   logic [31:0] fields_ff [4];
   logic [31:0] fields_in [4];
   logic [15:0] record_index_ff, record_index_in;
   logic        outside_ff, outside_in;
   logic [POS_BITS-1:0] pos_ff, pos_in;

   logic                 live;
   logic                 in_dir;
   logic                 emit;
   logic [32:0]          rec_end;
   logic                 oob;
   logic [NEED_BITS-1:0] need;
   status_type           st;
   logic [2:0]           slot;

   always_comb begin
      live            = byte_count_ff != '1;
      word_shift_in   = {word_shift_ff[23:0], data_byte};
      signature_in    = signature_ff;
      flavor_in       = flavor_ff;
      declared_in     = declared_ff;
      table_count_in  = table_count_ff;
      fields_in       = fields_ff;
      record_index_in = record_index_ff;
      outside_in      = outside_ff;
      pos_in          = pos_ff;
      byte_count_in   = byte_count_ff;
      emit            = 1'b0;
      slot            = pos_ff[POS_BITS-1:2];
      in_dir          = byte_count_ff >= COUNT_BITS'(HEADER_BYTES);
      rec_end         = {1'b0, fields_ff[1]} + {1'b0, fields_ff[2]};
      oob             = rec_end > {1'b0, declared_ff};

      if (live) begin
         if (byte_count_ff == COUNT_BITS'(3)) begin
            signature_in = word_shift_in;
         end
         if (byte_count_ff == COUNT_BITS'(7)) begin
            flavor_in = word_shift_in;
         end
         if (byte_count_ff == COUNT_BITS'(11)) begin
            declared_in = word_shift_in;
         end
         if (byte_count_ff == COUNT_BITS'(13)) begin
            table_count_in = word_shift_in[15:0];
         end
         if (in_dir) begin
            pos_in = (pos_ff == POS_BITS'(RECORD_BYTES - 1)) ? '0 : pos_ff + 1'b1;
            if (record_index_ff < table_count_ff && pos_ff[1:0] == 2'd3) begin
               if (slot < 3'd4) begin
                  fields_in[slot[1:0]] = word_shift_in;
               end else begin
                  emit            = 1'b1;
                  record_index_in = record_index_ff + 16'd1;
                  if (oob) begin
                     outside_in = 1'b1;
                  end
               end
            end
         end
         byte_count_in = byte_count_ff + 1'b1;
      end

      need = NEED_BITS'(HEADER_BYTES) + (NEED_BITS'(table_count_in) << 4)
           + (NEED_BITS'(table_count_in) << 2);

      priority if (byte_count_in < COUNT_BITS'(HEADER_BYTES)) begin
         st = ST_SHORT;
      end else if (signature_in != WOFF_MAGIC) begin
         st = ST_BAD_SIG;
      end else if (byte_count_in == '1 || declared_in != 32'(byte_count_in)) begin
         st = ST_LEN_MISM;
      end else if (33'(need) > 33'(byte_count_in)) begin
         st = ST_TRUNC_DIR;
      end else if (outside_in) begin
         st = ST_OUTSIDE;
      end else begin
         st = ST_OK;
      end

      push.rec_valid           = item_valid && emit;
      push.rec.kind            = KIND_RECORD;
      push.rec.table_index     = record_index_ff;
      push.rec.tag             = fields_ff[0];
      push.rec.table_offset    = fields_ff[1];
      push.rec.comp_length     = fields_ff[2];
      push.rec.orig_length     = fields_ff[3];
      push.rec.table_checksum  = word_shift_in;
      push.rec.is_compressed   = fields_ff[2] != fields_ff[3];
      push.rec.out_of_bounds   = oob;
      push.rec.status          = ST_OK;
      push.rec.flavor          = '0;
      push.rec.last_out        = 1'b0;

      push.stat_valid          = item_valid && last;
      push.stat.kind           = KIND_STATUS;
      push.stat.table_index    = record_index_in;
      push.stat.tag            = '0;
      push.stat.table_offset   = '0;
      push.stat.comp_length    = '0;
      push.stat.orig_length    = '0;
      push.stat.table_checksum = '0;
      push.stat.is_compressed  = 1'b0;
      push.stat.out_of_bounds  = 1'b0;
      push.stat.status         = st;
      push.stat.flavor         = flavor_in;
      push.stat.last_out       = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset || (item_valid && last)) begin
         byte_count_ff   <= '0;
         word_shift_ff   <= '0;
         signature_ff    <= '0;
         flavor_ff       <= '0;
         declared_ff     <= '0;
         table_count_ff  <= '0;
         record_index_ff <= '0;
         outside_ff      <= 1'b0;
         pos_ff          <= '0;
      end else if (item_valid) begin
         byte_count_ff   <= byte_count_in;
         word_shift_ff   <= word_shift_in;
         signature_ff    <= signature_in;
         flavor_ff       <= flavor_in;
         declared_ff     <= declared_in;
         table_count_ff  <= table_count_in;
         record_index_ff <= record_index_in;
         outside_ff      <= outside_in;
         pos_ff          <= pos_in;
      end
   end

   // record fields are always rewritten before a record is emitted
   always_ff @(posedge clock) begin
      if (item_valid) begin
         fields_ff <= fields_in;
      end
   end

endmodule

>>> hw/rtl/whdp_queue.sv
// ----------------------------------------------------------------------------
// WOFF header directory parser: result queue
// Small queue taking up to two result items per cycle, one out per cycle on pop.
// ----------------------------------------------------------------------------
module whdp_queue (
   input  logic                clock,
   input  logic                reset,
   input  whdp_pkg::push_type  push,
   output whdp_pkg::rsp_type   head,
   output logic                head_valid,
   input  logic                pop,
   output whdp_pkg::level_type level
);
   import whdp_pkg::*;

   rsp_type   entry_ff [RSP_DEPTH];
   ptr_type   rd_ptr_ff, rd_ptr_in;
   ptr_type   wr_ptr_ff, wr_ptr_in;
   level_type level_ff, level_in;
   rsp_type   first;
   logic [1:0] n_push;
   logic       do_pop;

   always_comb begin
      first      = push.rec_valid ? push.rec : push.stat;
      n_push     = {1'b0, push.rec_valid} + {1'b0, push.stat_valid};
      do_pop     = pop && (level_ff != '0);
      rd_ptr_in  = rd_ptr_ff + ptr_type'(do_pop);
      wr_ptr_in  = wr_ptr_ff + ptr_type'(n_push);
      level_in   = level_ff + level_type'(n_push) - level_type'(do_pop);
      head       = entry_ff[rd_ptr_ff];
      head_valid = level_ff != '0;
      level      = level_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         entry_ff[wr_ptr_ff] <= first;
      end
      if (n_push == 2'd2) begin
         entry_ff[wr_ptr_ff + 1'b1] <= push.stat;
      end
   end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// WOFF header directory parser testbench
// Sends WOFF byte streams into the parser and checks every table record and
// final status against an in-bench parser model. A directed table of short
// files comes first, then random files: well-formed ones with their
// directories, and ones that are cut short, carry a bad signature, give a
// wrong length, lose part of the directory or are plain noise. Both channels
// idle at random in phases, and the last phase runs without idling.
// ----------------------------------------------------------------------------
module tb_top;

   import whdp_pkg::*;

   localparam int DIR_ROWS   = 22;
   localparam int RAND_BYTES = 1200;
   localparam int IDLE_LIMIT = 4000;
   localparam int TAIL       = 20;

   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic        typed;   // expected status typed into the table
      status_type  st;
      logic [31:0] flav;
   } stim_type;

   // short files whose final status is plain from the bytes alone
   stim_type directed_rows [DIR_ROWS] = '{
      '{8'h00, 1'b1, 1'b1, ST_SHORT, 32'h0000_0000},
      '{8'hFF, 1'b1, 1'b1, ST_SHORT, 32'h0000_0000},
      '{8'h77, 1'b0, 1'b0, ST_OK,    32'h0000_0000},
      '{8'h4F, 1'b0, 1'b0, ST_OK,    32'h0000_0000},
      '{8'h46, 1'b0, 1'b0, ST_OK,    32'h0000_0000},
      '{8'h46, 1'b0, 1'b0, ST_OK,    32'h0000_0000},
      '{8'hDE, 1'b0, 1'b0, ST_OK,    32'h0000_0000},
      '{8'hAD, 1'b0, 1'b0, ST_OK,    32'h0000_0000},
      '{8'hBE, 1'b0, 1'b0, ST_OK,    32'h0000_0000},
      '{8'hEF, 1'b1, 1'b1, ST_SHORT, 32'hDEAD_BEEF},
      '{8'h00, 1'b0, 1'b0, ST_OK,    32'h0000_0000},
      '{8'h00, 1'b0, 1'b0, ST_OK,    32'h0000_0000},
      '{8'h00, 1'b0, 1'b0, ST_OK,    32'h0000_0000},
      '{8'h00, 1'b0, 1'b0, ST_OK,    32'h0000_0000},
      '{8'hFF, 1'b0, 1'b0, ST_OK,    32'h0000_0000},
      '{8'hFF, 1'b0, 1'b0, ST_OK,    32'h0000_0000},
      '{8'hFF, 1'b0, 1'b0, ST_OK,    32'h0000_0000},
      '{8'hFF, 1'b0, 1'b0, ST_OK,    32'h0000_0000},
      '{8'hFF, 1'b0, 1'b0, ST_OK,    32'h0000_0000},
      '{8'hFF, 1'b0, 1'b0, ST_OK,    32'h0000_0000},
      '{8'hFF, 1'b0, 1'b0, ST_OK,    32'h0000_0000},
      '{8'hFF, 1'b1, 1'b1, ST_SHORT, 32'hFFFF_FFFF}
   };

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata;
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [215:0] rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;

   stim_type on_wire = '0;
   stim_type byte_stream [$];
   rsp_type  due_results [$];

   // parser model state
   count_type   file_bytes;
   logic [31:0] tail_word;
   logic [31:0] magic_word;
   logic [31:0] font_flavor;
   logic [31:0] stated_length;
   logic [15:0] dir_entries;
   logic [31:0] entry_word [4];
   logic [15:0] entries_out;
   logic        bound_hit;

   int total_items;
   int bytes_in;
   int results_out;
   int records_seen;
   int files_built;
   int mismatches;
   int idle_cycles;
   int status_hist [6];

   assign req_tdata = on_wire.data;
   assign req_tlast = on_wire.last;

   woff_header_directory_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void clear_parser();
      file_bytes    = '0;
      tail_word     = '0;
      magic_word    = '0;
      font_flavor   = '0;
      stated_length = '0;
      dir_entries   = '0;
      for (int k = 0; k < 4; k++) entry_word[k] = '0;
      entries_out   = '0;
      bound_hit     = 1'b0;
   endfunction

   // advance the model by one accepted byte and queue what it gives
   function automatic void parse_woff_byte(input stim_type it);
      count_type   seen;
      logic        live;
      logic [31:0] rec_pos;
      logic [32:0] span;
      rsp_type     res;
      count_type   n;
      seen = file_bytes;
      live = (seen != '1);
      tail_word = {tail_word[23:0], it.data};
      if (live) begin
         if (seen == 3) magic_word = tail_word;
         else if (seen == 7) font_flavor = tail_word;
         else if (seen == 11) stated_length = tail_word;
         else if (seen == 13) dir_entries = tail_word[15:0];
         if (seen >= HEADER_BYTES && entries_out < dir_entries) begin
            rec_pos = (32'(seen) - HEADER_BYTES) % RECORD_BYTES;
            if (rec_pos[1:0] == 2'b11) begin
               if ((rec_pos >> 2) < 4) begin
                  entry_word[rec_pos >> 2] = tail_word;
               end else begin
                  span = {1'b0, entry_word[1]} + {1'b0, entry_word[2]};
                  res = '0;
                  res.kind           = KIND_RECORD;
                  res.table_index    = entries_out;
                  res.tag            = entry_word[0];
                  res.table_offset   = entry_word[1];
                  res.comp_length    = entry_word[2];
                  res.orig_length    = entry_word[3];
                  res.table_checksum = tail_word;
                  res.is_compressed  = (entry_word[2] != entry_word[3]);
                  res.out_of_bounds  = (span > {1'b0, stated_length});
                  if (res.out_of_bounds) bound_hit = 1'b1;
                  entries_out = entries_out + 16'd1;
                  due_results = {due_results, res};
               end
            end
         end
         file_bytes = seen + 1'b1;
      end
      if (it.last) begin
         n = file_bytes;
         res = '0;
         res.kind        = KIND_STATUS;
         res.table_index = entries_out;
         res.flavor      = font_flavor;
         res.last_out    = 1'b1;
         if (n < HEADER_BYTES) res.status = ST_SHORT;
         else if (magic_word != WOFF_MAGIC) res.status = ST_BAD_SIG;
         else if (n == '1 || stated_length != 32'(n)) res.status = ST_LEN_MISM;
         else if (longint'(HEADER_BYTES) + longint'(dir_entries) * RECORD_BYTES
                  > longint'(n))
            res.status = ST_TRUNC_DIR;
         else if (bound_hit) res.status = ST_OUTSIDE;
         else res.status = ST_OK;
         if (it.typed) begin
            res = '0;
            res.kind     = KIND_STATUS;
            res.status   = it.st;
            res.flavor   = it.flav;
            res.last_out = 1'b1;
         end
         due_results = {due_results, res};
         clear_parser();
      end
   endfunction

   function automatic void put_word(ref logic [7:0] q [$], input logic [31:0] w);
      q = {q, w[31:24]};
      q = {q, w[23:16]};
      q = {q, w[15:8]};
      q = {q, w[7:0]};
   endfunction

   function automatic void set_word(ref logic [7:0] q [$], input int at,
                                    input logic [31:0] w);
      q[at]   = w[31:24];
      q[at+1] = w[23:16];
      q[at+2] = w[15:8];
      q[at+3] = w[7:0];
   endfunction

   // one random file: mostly well formed, some broken in one way or another
   function automatic void queue_random_file();
      logic [7:0]  img [$];
      int          ntab;
      int          extra;
      int          total;
      int          mode;
      int          cut;
      int          delta;
      logic [31:0] off;
      logic [31:0] clen;
      stim_type    it;
      mode  = $urandom_range(99, 0);
      ntab  = ($urandom_range(9, 0) == 0) ? $urandom_range(8, 5) : $urandom_range(4, 0);
      extra = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(24, 1);
      total = HEADER_BYTES + RECORD_BYTES * ntab + extra;
      put_word(img, WOFF_MAGIC);
      put_word(img, $urandom);
      put_word(img, total);
      img = {img, 8'(ntab >> 8)};
      img = {img, 8'(ntab)};
      repeat (30) img = {img, 8'($urandom)};
      for (int t = 0; t < ntab; t++) begin
         case ($urandom_range(9, 0))
            0: begin
               off  = $urandom;
               clen = $urandom;
            end
            1: begin
               off  = 32'hFFFF_FFFF;
               clen = ($urandom_range(1, 0) == 0) ? 32'hFFFF_FFFF : 32'(total);
            end
            2: begin
               off  = $urandom_range(total, 0);
               clen = total - off + $urandom_range(1, 0);
            end
            default: begin
               off  = $urandom_range(total, 0);
               clen = $urandom_range(total - off, 0);
            end
         endcase
         put_word(img, $urandom);
         put_word(img, off);
         put_word(img, clen);
         put_word(img, ($urandom_range(1, 0) == 0) ? clen : 32'($urandom));
         put_word(img, $urandom);
      end
      repeat (extra) img = {img, 8'($urandom)};
      if (mode < 8) begin
         img.delete();
         repeat ($urandom_range(60, 1)) img = {img, 8'($urandom)};
      end else if (mode < 14) begin
         cut = $urandom_range(HEADER_BYTES - 1, 1);
         img = img[0:cut-1];
      end else if (mode < 22) begin
         img[$urandom_range(3, 0)] ^= 8'(1 << $urandom_range(7, 0));
      end else if (mode < 32) begin
         delta = $urandom_range(3, 1);
         if ($urandom_range(3, 0) == 0) set_word(img, 8, $urandom);
         else if ($urandom_range(1, 0) == 0) set_word(img, 8, total + delta);
         else set_word(img, 8, total - delta);
      end else if (mode < 42) begin
         if (ntab > 0) begin
            cut = $urandom_range(HEADER_BYTES + RECORD_BYTES * ntab - 1, HEADER_BYTES);
            img = img[0:cut-1];
         end else begin
            img[12] = 8'($urandom);
            img[13] = 8'($urandom_range(255, 1));
            cut = total;
         end
         set_word(img, 8, cut);
      end
      foreach (img[i]) begin
         it      = '0;
         it.data = img[i];
         it.last = (i == img.size() - 1);
         byte_stream = {byte_stream, it};
      end
      files_built++;
   endfunction

   task automatic note_mismatch(input string field, input logic [31:0] got,
                                input logic [31:0] want);
      $display("result %0d: %s is %h, expected %h", results_out, field, got, want);
      mismatches++;
   endtask

   task automatic check_result(input rsp_type got, input rsp_type want);
      if (got.kind !== want.kind) note_mismatch("kind", got.kind, want.kind);
      if (got.table_index !== want.table_index)
         note_mismatch("table_index", got.table_index, want.table_index);
      if (got.tag !== want.tag) note_mismatch("tag", got.tag, want.tag);
      if (got.table_offset !== want.table_offset)
         note_mismatch("table_offset", got.table_offset, want.table_offset);
      if (got.comp_length !== want.comp_length)
         note_mismatch("comp_length", got.comp_length, want.comp_length);
      if (got.orig_length !== want.orig_length)
         note_mismatch("orig_length", got.orig_length, want.orig_length);
      if (got.table_checksum !== want.table_checksum)
         note_mismatch("table_checksum", got.table_checksum, want.table_checksum);
      if (got.is_compressed !== want.is_compressed)
         note_mismatch("is_compressed", got.is_compressed, want.is_compressed);
      if (got.out_of_bounds !== want.out_of_bounds)
         note_mismatch("out_of_bounds", got.out_of_bounds, want.out_of_bounds);
      if (got.status !== want.status) note_mismatch("status", got.status, want.status);
      if (got.flavor !== want.flavor) note_mismatch("flavor", got.flavor, want.flavor);
      if (got.last_out !== want.last_out)
         note_mismatch("last_out", got.last_out, want.last_out);
   endtask

   function automatic int send_idle_pct();
      int phase;
      phase = (total_items == 0) ? 0 : bytes_in * 3 / total_items;
      return (phase == 0) ? 18 : (phase == 1) ? 48 : 0;
   endfunction

   function automatic int recv_idle_pct();
      int phase;
      phase = (total_items == 0) ? 0 : bytes_in * 3 / total_items;
      return (phase == 0) ? 48 : (phase == 1) ? 18 : 0;
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (byte_stream.size() > 0 && $urandom_range(99, 0) >= send_idle_pct()) begin
            req_tvalid <= 1'b1;
            on_wire    <= byte_stream[0];
            void'(byte_stream.pop_front());
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99, 0) >= recv_idle_pct());
      end
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         parse_woff_byte(on_wire);
         bytes_in++;
      end
   end

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got                = '0;
         got.kind           = rsp_tuser;
         got.table_index    = rsp_tdata[15:0];
         got.tag            = rsp_tdata[47:16];
         got.table_offset   = rsp_tdata[79:48];
         got.comp_length    = rsp_tdata[111:80];
         got.orig_length    = rsp_tdata[143:112];
         got.table_checksum = rsp_tdata[175:144];
         got.is_compressed  = rsp_tdata[176];
         got.out_of_bounds  = rsp_tdata[177];
         got.status         = status_type'(rsp_tdata[180:178]);
         got.flavor         = rsp_tdata[212:181];
         got.last_out       = rsp_tlast;
         if (due_results.size() == 0) begin
            note_mismatch("unsolicited item, kind", got.kind, 32'h0);
         end else begin
            want = due_results.pop_front();
            check_result(got, want);
            if (want.kind == KIND_STATUS) status_hist[int'(want.status)]++;
            else records_seen++;
         end
         results_out++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d cycles without an item", idle_cycles);
         $display("woff_header_directory_parser verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      clear_parser();
      for (int r = 0; r < DIR_ROWS; r++) byte_stream = {byte_stream, directed_rows[r]};
      while (byte_stream.size() < DIR_ROWS + RAND_BYTES) queue_random_file();
      total_items = byte_stream.size();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      while (bytes_in < total_items) @(posedge clock);
      while (due_results.size() > 0) @(posedge clock);
      repeat (TAIL) @(posedge clock);
      if (due_results.size() > 0)
         note_mismatch("results never returned", due_results.size(), 32'h0);
      $display("Sent %0d bytes in %0d random files plus the directed table; %0d results",
               total_items, files_built, results_out);
      $display("Table records %0d; status ok %0d short %0d sig %0d len %0d trunc %0d out %0d",
               records_seen, status_hist[0], status_hist[1], status_hist[2],
               status_hist[3], status_hist[4], status_hist[5]);
      if (mismatches == 0) begin
         $display("woff_header_directory_parser verification clean");
      end else begin
         $display("woff_header_directory_parser verification failed");
      end
      $finish;
   end

endmodule
